/* hw/rtl/wvlt3d_pkg.sv */
package wvlt3d_pkg;

  // coordinate width default
  localparam int COORD_BITS_DEF = 16;

  // field widths
  localparam int LEVEL_W    = 4;
  localparam int TYPE_W     = 3;
  localparam int LIMIT_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // highest level a 4-bit level register can name; bits of a coordinate examined
  localparam int LOW_W = (1 << LEVEL_W) - 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_LIMIT = 2'd1;

  // register reset values
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST   = 4'd4;
  localparam logic [LIMIT_W-1:0] COORD_LIMIT_RST = 17'h10000;

  // coefficient type codes, bit0 x, bit1 y, bit2 z; 1 marks a wavelet axis
  localparam logic [TYPE_W-1:0] TYPE_SCALING = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_X       = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_Y       = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_XY      = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_Z       = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_XZ      = 3'd5;
  localparam logic [TYPE_W-1:0] TYPE_YZ      = 3'd6;

  // live configuration handed to the classifiers
  typedef struct packed {
    logic [LEVEL_W-1:0] max_level;
    logic [LIMIT_W-1:0] coordinate_limit;
  } cfg_t;

  // classification of one axis
  typedef struct packed {
    logic               wavelet;
    logic               oor;
    logic [LEVEL_W-1:0] level;
  } axis_t;

endpackage

/* hw/rtl/wvlt3d_if.sv */
// vertex input channel
interface wvlt3d_in_if #(
  parameter int COORD_BITS = wvlt3d_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  logic [COORD_BITS-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

// classification result channel
interface wvlt3d_out_if ();
  import wvlt3d_pkg::*;
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  coeff_type;
  logic [LEVEL_W-1:0] coeff_level;
  logic               out_of_range;

  modport source (output valid, output coeff_type, output coeff_level, output out_of_range,
                  input ready);
  modport sink   (input valid, input coeff_type, input coeff_level, input out_of_range,
                  output ready);
endinterface

// register write channel
interface wvlt3d_cfg_if ();
  import wvlt3d_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/wvlt3d_cfg.sv */
module wvlt3d_cfg (
  input  logic              clk,
  input  logic              rst,
  wvlt3d_cfg_if.sink        cfg_wr,
  output wvlt3d_pkg::cfg_t  cfg
);
  import wvlt3d_pkg::*;

  logic [LEVEL_W-1:0] max_level;
  logic [LIMIT_W-1:0] coordinate_limit;

  // writes never stall
  assign cfg_wr.ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_level        <= MAX_LEVEL_RST;
      coordinate_limit <= COORD_LIMIT_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_MAX_LEVEL:   max_level        <= cfg_wr.data[LEVEL_W-1:0];
        REG_COORD_LIMIT: coordinate_limit <= cfg_wr.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.max_level        = max_level;
  assign cfg.coordinate_limit = coordinate_limit;

endmodule

/* hw/rtl/wvlt3d_axis.sv */
module wvlt3d_axis #(
  parameter int COORD_BITS = wvlt3d_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] coord,
  input  wvlt3d_pkg::cfg_t      cfg,
  output wvlt3d_pkg::axis_t     cls
);
  import wvlt3d_pkg::*;

  localparam int CMP_W = (COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W;

  logic [LOW_W-1:0] low;

  // low coordinate bits, zero above the coordinate width
  for (genvar i = 0; i < LOW_W; i++) begin : g_low
    if (i < COORD_BITS) begin : g_bit
      assign low[i] = coord[i];
    end else begin : g_zero
      assign low[i] = 1'b0;
    end
  end

  // lowest set bit below max_level gives the wavelet level; none means scaling
  // range check against the grid size
  always_comb begin
    cls.oor     = (CMP_W'(coord) >= CMP_W'(cfg.coordinate_limit));
    cls.wavelet = 1'b0;
    cls.level   = cfg.max_level;
    for (int i = LOW_W - 1; i >= 0; i--) begin
      if (low[i] && (i < int'(cfg.max_level))) begin
        cls.wavelet = 1'b1;
        cls.level   = LEVEL_W'(i + 1);
      end
    end
  end

endmodule

/* hw/rtl/wvlt3d_pick.sv */
module wvlt3d_pick (
  input  wvlt3d_pkg::axis_t                     ax,
  input  wvlt3d_pkg::axis_t                     ay,
  input  wvlt3d_pkg::axis_t                     az,
  output logic [wvlt3d_pkg::TYPE_W-1:0]         coeff_type,
  output logic [wvlt3d_pkg::LEVEL_W-1:0]        coeff_level,
  output logic                                  out_of_range
);
  import wvlt3d_pkg::*;

  logic [TYPE_W-1:0]  raw;
  logic [LEVEL_W-1:0] lmin;
  logic               eq_xy;
  logic               eq_yz;
  logic               eq_zx;

  assign raw   = {az.wavelet, ay.wavelet, ax.wavelet};
  assign eq_xy = (ax.level == ay.level);
  assign eq_yz = (ay.level == az.level);
  assign eq_zx = (az.level == ax.level);

  // least level of the three axes
  always_comb begin
    lmin = ax.level;
    if (ay.level < lmin) lmin = ay.level;
    if (az.level < lmin) lmin = az.level;
  end

  // type selection; ties resolved towards the equal pair or the finest axis
  always_comb begin
    if (raw inside {TYPE_SCALING, TYPE_X, TYPE_Y, TYPE_Z}) begin
      coeff_type = raw;
    end else if (eq_xy && eq_zx) begin
      coeff_type = raw;
    end else if (eq_xy) begin
      coeff_type = (lmin == ax.level) ? TYPE_XY : TYPE_Z;
    end else if (eq_yz) begin
      coeff_type = (lmin == ay.level) ? TYPE_YZ : TYPE_X;
    end else if (eq_zx) begin
      coeff_type = (lmin == ax.level) ? TYPE_XZ : TYPE_Y;
    end else if (lmin == ax.level) begin
      coeff_type = TYPE_X;
    end else if (lmin == ay.level) begin
      coeff_type = TYPE_Y;
    end else begin
      coeff_type = TYPE_Z;
    end
  end

  assign coeff_level  = lmin;
  assign out_of_range = ax.oor | ay.oor | az.oor;

endmodule

/* hw/rtl/wavelet_vertex_level_type_3d_top.sv */
// Wavelet vertex level and type classifier, three dimensions.
//
// in_ch  : one vertex (coord_x, coord_y, coord_z) per item, valid/ready.
// out_ch : one result per vertex: coeff_type (bits z,y,x, 1 = wavelet),
//          coeff_level (least axis level) and out_of_range.
// cfg_wr : register writes, index 0 max_level, index 1 coordinate_limit;
//          other indexes are dropped. Always ready. Write only while idle.
//
// An accepted vertex passes an input register, then the per-axis trailing-zero
// search, range compare and type pick, then the result register. One vertex
// per cycle is sustained while out_ch is ready; the depth of the trailing-zero
// priority logic sets the cycle time.
//
// Reset (rst, synchronous) empties both stages and loads max_level = 4 and
// coordinate_limit = 65536. When the receiver stalls, the result register
// holds its item and the input register takes one more vertex only if it is
// empty; ready on in_ch then drops until out_ch drains.
module wavelet_vertex_level_type_3d_top #(
  parameter int COORD_BITS = wvlt3d_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  wvlt3d_in_if.sink     in_ch,
  wvlt3d_out_if.source  out_ch,
  wvlt3d_cfg_if.sink    cfg_wr
);
  import wvlt3d_pkg::*;

  cfg_t cfg;
  axis_t ax;
  axis_t ay;
  axis_t az;

  logic                  s1_valid;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [COORD_BITS-1:0] s1_z;
  logic                  s1_adv;

  logic [TYPE_W-1:0]  pick_type;
  logic [LEVEL_W-1:0] pick_level;
  logic               pick_oor;

  logic               res_valid;
  logic [TYPE_W-1:0]  res_type;
  logic [LEVEL_W-1:0] res_level;
  logic               res_oor;

  // registers
  wvlt3d_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // pipeline flow control
  assign s1_adv      = !res_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_x <= in_ch.coord_x;
      s1_y <= in_ch.coord_y;
      s1_z <= in_ch.coord_z;
    end
  end

  // per-axis classification
  wvlt3d_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (.coord(s1_x), .cfg(cfg), .cls(ax));
  wvlt3d_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (.coord(s1_y), .cfg(cfg), .cls(ay));
  wvlt3d_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (.coord(s1_z), .cfg(cfg), .cls(az));

  // type and level selection
  wvlt3d_pick u_pick (
    .ax           (ax),
    .ay           (ay),
    .az           (az),
    .coeff_type   (pick_type),
    .coeff_level  (pick_level),
    .out_of_range (pick_oor)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      res_type  <= pick_type;
      res_level <= pick_level;
      res_oor   <= pick_oor;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.coeff_type   = res_type;
  assign out_ch.coeff_level  = res_level;
  assign out_ch.out_of_range = res_oor;

endmodule

/* hw/rtl/wvlt3d_chk.sv */
module wvlt3d_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [wvlt3d_pkg::TYPE_W-1:0]     coeff_type,
  input logic [wvlt3d_pkg::LEVEL_W-1:0]    coeff_level,
  input logic                              out_of_range
);
  import wvlt3d_pkg::*;

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an accepted vertex reaches the result register when the sink is ready while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("vertex lost in pipeline");

  // any wavelet axis implies a level of at least one
  a_wavelet_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (coeff_type != TYPE_SCALING)) |-> (coeff_level != '0))
    else $error("wavelet type with level zero");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      ($stable(coeff_type) && $stable(coeff_level) && $stable(out_of_range)))
    else $error("result changed while stalled");

endmodule

bind wavelet_vertex_level_type_3d_top wvlt3d_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .coeff_type   (out_ch.coeff_type),
  .coeff_level  (out_ch.coeff_level),
  .out_of_range (out_ch.out_of_range)
);

/* dv/wavelet_vertex_level_type_3d_top_tb.sv */
`timescale 1ns / 100ps

module wavelet_vertex_level_type_3d_top_tb;
  import wvlt3d_pkg::*;

  localparam int COORD_BITS   = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int CHUNK_ITEMS  = 84;
  localparam int CHUNKS       = 4;

  // register slots that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  coeff_type;
    logic [LEVEL_W-1:0] coeff_level;
    logic               out_of_range;
  } vertex_class_t;

  logic clk;
  logic rst;

  wvlt3d_in_if #(.COORD_BITS(COORD_BITS)) vtx_in ();
  wvlt3d_out_if                           cls_out ();
  wvlt3d_cfg_if                           reg_wr ();

  wavelet_vertex_level_type_3d_top #(.COORD_BITS(COORD_BITS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (vtx_in),
    .out_ch (cls_out),
    .cfg_wr (reg_wr)
  );

  // shadow copy of the block's registers
  logic [LEVEL_W-1:0] shadow_max_level;
  logic [LIMIT_W-1:0] shadow_coord_limit;

  vertex_class_t pending_class[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct;
  int            recv_stall_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wavelet_vertex_level_type_3d_top: mismatch");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    cls_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      cls_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one axis: scaling at max_level on a multiple of 2^max_level, else wavelet
  function automatic void classify_axis(input coord_t c, output logic wav,
                                        output logic [LEVEL_W-1:0] lvl);
    logic [31:0] mask;
    coord_t      low;
    int          tz;
    mask = (32'd1 << shadow_max_level) - 32'd1;
    low  = c & mask[COORD_BITS-1:0];
    if (low == '0) begin
      wav = 1'b0;
      lvl = shadow_max_level;
    end else begin
      tz = 0;
      while (!low[tz]) tz++;
      wav = 1'b1;
      lvl = LEVEL_W'(tz + 1);
    end
  endfunction

  // full vertex classification with the tie rules
  function automatic vertex_class_t classify_vertex(input coord_t x, input coord_t y,
                                                    input coord_t z);
    vertex_class_t      res;
    logic               wx, wy, wz;
    logic [LEVEL_W-1:0] lx, ly, lz, lmin;
    logic [TYPE_W-1:0]  raw;
    classify_axis(x, wx, lx);
    classify_axis(y, wy, ly);
    classify_axis(z, wz, lz);
    lmin = lx;
    if (ly < lmin) lmin = ly;
    if (lz < lmin) lmin = lz;
    raw = {wz, wy, wx};
    if (raw == TYPE_SCALING || raw == TYPE_X || raw == TYPE_Y || raw == TYPE_Z)
      res.coeff_type = raw;
    else if (lx == ly && lx == lz)
      res.coeff_type = raw;
    else if (lx == ly)
      res.coeff_type = (lmin == lx) ? TYPE_XY : TYPE_Z;
    else if (ly == lz)
      res.coeff_type = (lmin == ly) ? TYPE_YZ : TYPE_X;
    else if (lz == lx)
      res.coeff_type = (lmin == lx) ? TYPE_XZ : TYPE_Y;
    else if (lmin == lx)
      res.coeff_type = TYPE_X;
    else if (lmin == ly)
      res.coeff_type = TYPE_Y;
    else
      res.coeff_type = TYPE_Z;
    res.coeff_level  = lmin;
    res.out_of_range = (x >= shadow_coord_limit) || (y >= shadow_coord_limit) ||
                       (z >= shadow_coord_limit);
    return res;
  endfunction

  // result check against the oldest expected classification
  always @(posedge clk) begin
    vertex_class_t want;
    if (!rst && cls_out.valid && cls_out.ready) begin
      if (pending_class.size() == 0) begin
        $error("unexpected result: coeff_type %0d coeff_level %0d out_of_range %0d",
               cls_out.coeff_type, cls_out.coeff_level, cls_out.out_of_range);
        fail_count++;
      end else begin
        want = pending_class.pop_front();
        if (cls_out.coeff_type !== want.coeff_type) begin
          $error("coeff_type expected %0d actual %0d", want.coeff_type, cls_out.coeff_type);
          fail_count++;
        end
        if (cls_out.coeff_level !== want.coeff_level) begin
          $error("coeff_level expected %0d actual %0d", want.coeff_level,
                 cls_out.coeff_level);
          fail_count++;
        end
        if (cls_out.out_of_range !== want.out_of_range) begin
          $error("out_of_range expected %0d actual %0d", want.out_of_range,
                 cls_out.out_of_range);
          fail_count++;
        end
      end
    end
  end

  // send one vertex, with random idle cycles in front
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_in.valid <= 1'b0;
      @(posedge clk);
    end
    vtx_in.valid   <= 1'b1;
    vtx_in.coord_x <= x;
    vtx_in.coord_y <= y;
    vtx_in.coord_z <= z;
    @(posedge clk);
    while (!vtx_in.ready) @(posedge clk);
    pending_class = {pending_class, classify_vertex(x, y, z)};
  endtask

  // hold off the sender until every expected result has come back
  task automatic wait_results_drained();
    vtx_in.valid <= 1'b0;
    while (pending_class.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_results_drained();
    reg_wr.valid <= 1'b1;
    reg_wr.index <= idx;
    reg_wr.data  <= value;
    @(posedge clk);
    while (!reg_wr.ready) @(posedge clk);
    reg_wr.valid <= 1'b0;
    if (idx == REG_MAX_LEVEL)
      shadow_max_level = value[LEVEL_W-1:0];
    else if (idx == REG_COORD_LIMIT)
      shadow_coord_limit = value[LIMIT_W-1:0];
  endtask

  // reset values, every type code and each tie rule (levels 1..3 at max_level 4)
  task automatic test_types_and_ties();
    send_vertex(16'd0, 16'd0, 16'd0);
    send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vertex(16'hFFFF, 16'd0, 16'h8000);
    send_vertex(16'd1, 16'd16, 16'd16);
    send_vertex(16'd1, 16'd1, 16'd2);    // x,y tie at the least level
    send_vertex(16'd2, 16'd2, 16'd1);    // x,y tie above z
    send_vertex(16'd2, 16'd1, 16'd1);    // y,z tie at the least level
    send_vertex(16'd1, 16'd2, 16'd2);    // y,z tie above x
    send_vertex(16'd1, 16'd2, 16'd1);    // z,x tie at the least level
    send_vertex(16'd2, 16'd1, 16'd2);    // z,x tie above y
    send_vertex(16'd1, 16'd2, 16'd4);    // all differ, x least
    send_vertex(16'd2, 16'd1, 16'd4);
    send_vertex(16'd4, 16'd2, 16'd1);
    send_vertex(16'd1, 16'd16, 16'd1);   // z,x tie at the least level, scaling y above
  endtask

  // register extremes, zero level, zero limit and undecoded indexes
  task automatic test_register_extremes();
    write_register(REG_MAX_LEVEL, 17'd15);
    send_vertex(16'h8000, 16'd0, 16'h4000);
    write_register(REG_MAX_LEVEL, 17'd0);
    send_vertex(16'hFFFF, 16'd1, 16'd0);
    write_register(REG_COORD_LIMIT, 17'd0);
    send_vertex(16'd0, 16'd0, 16'd0);
    write_register(REG_MAX_LEVEL, 17'd1);
    write_register(REG_COORD_LIMIT, 17'd1);
    send_vertex(16'd0, 16'd0, 16'd0);
    send_vertex(16'd0, 16'd1, 16'd0);
    write_register(REG_COORD_LIMIT, 17'h1FFFF);
    send_vertex(16'hFFFF, 16'hFFFE, 16'hFFFF);
    write_register(REG_COORD_LIMIT, 17'hFFFF);
    send_vertex(16'd0, 16'd0, 16'hFFFF);
    send_vertex(16'hFFFE, 16'hFFFE, 16'hFFFE);
    // writes to undecoded slots must leave both registers alone
    write_register(REG_SPARE_A, 17'd0);
    write_register(REG_SPARE_B, 17'd0);
    send_vertex(16'hFFFF, 16'd2, 16'd4);
    write_register(REG_MAX_LEVEL, CFG_DATA_W'(MAX_LEVEL_RST));
    write_register(REG_COORD_LIMIT, COORD_LIMIT_RST);
  endtask

  // one axis value; shared trailing-zero counts make ties common
  function automatic coord_t pick_coord(input int tz_a, input int tz_b);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = ($urandom | 32'd1) << tz_a;
      3, 4:    v = ($urandom | 32'd1) << tz_b;
      5:       v = $urandom;
      6:       v = $urandom << $urandom_range(8, 16);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'd0;
          1:       v = 32'hFFFF;
          default: v = 32'(shadow_coord_limit) - $urandom_range(0, 1);
        endcase
      end
    endcase
    return v[COORD_BITS-1:0];
  endfunction

  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] lvl;
    logic [CFG_DATA_W-1:0] lim;
    lvl = ($urandom_range(0, 9) == 0) ? 17'd0 : CFG_DATA_W'($urandom_range(1, 15));
    case ($urandom_range(0, 4))
      0:       lim = COORD_LIMIT_RST;
      1:       lim = CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
      2:       lim = CFG_DATA_W'($urandom_range(0, 16));
      default: lim = CFG_DATA_W'($urandom_range(16'h8000, 17'h10000));
    endcase
    write_register(REG_MAX_LEVEL, lvl);
    write_register(REG_COORD_LIMIT, lim);
    if ($urandom_range(0, 5) == 0)
      write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                     CFG_DATA_W'($urandom));
  endtask

  // random vertices under changing settings and four idling patterns
  task automatic test_random_traffic();
    int send_pcts[4] = '{0, 80, 0, 17};
    int recv_pcts[4] = '{0, 0, 80, 17};
    int tz_a;
    int tz_b;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int ch = 0; ch < CHUNKS; ch++) begin
        pick_settings();
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          tz_a = $urandom_range(0, 15);
          tz_b = $urandom_range(0, 15);
          send_vertex(pick_coord(tz_a, tz_b), pick_coord(tz_a, tz_b),
                      pick_coord(tz_a, tz_b));
          // sender holds off mid-chunk until the pipe is empty
          if (n == CHUNK_ITEMS / 2 && ch == 1) wait_results_drained();
        end
      end
    end
  endtask

  // stimulus sequence
  initial begin
    rst                = 1'b1;
    vtx_in.valid       = 1'b0;
    vtx_in.coord_x     = '0;
    vtx_in.coord_y     = '0;
    vtx_in.coord_z     = '0;
    reg_wr.valid       = 1'b0;
    reg_wr.index       = REG_MAX_LEVEL;
    reg_wr.data        = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    shadow_max_level   = MAX_LEVEL_RST;
    shadow_coord_limit = COORD_LIMIT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_types_and_ties();
    test_register_extremes();
    test_random_traffic();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("wavelet_vertex_level_type_3d_top: match");
    else
      $display("wavelet_vertex_level_type_3d_top: mismatch");
    $finish;
  end

endmodule

/* wavelet_vertex_level_type_3d_top.f */
hw/rtl/wvlt3d_pkg.sv
hw/rtl/wvlt3d_if.sv
hw/rtl/wvlt3d_cfg.sv
hw/rtl/wvlt3d_axis.sv
hw/rtl/wvlt3d_pick.sv
hw/rtl/wavelet_vertex_level_type_3d_top.sv
hw/rtl/wvlt3d_chk.sv
dv/wavelet_vertex_level_type_3d_top_tb.sv
